FILE: sv/renc_pkg.sv
// renc_pkg: shared types and constants for the rotary encoder counter
// used by renc_ctrl, renc_dp and rotary_encoder_accel_counter_unit
package renc_pkg;

   // request codes
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_EDGE = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCELERATE = 1'd1;

   // reset values of the configuration registers
   localparam logic [CSR_DATA_BITS-1:0] DEBOUNCE_RESET = 16'd2000;

   // step size: 1 + 100000 / elapsed, quotient developed one bit a cycle
   localparam int STEP_BITS = 17;
   localparam int DIV_CNT_BITS = 5;
   localparam logic [STEP_BITS-1:0] SPEED_NUMERATOR = 17'd100000;

   // output count width
   localparam int OUT_COUNT_BITS = 32;

   // controller to datapath commands
   typedef struct packed {
      logic tick;      // count one microsecond
      logic start;     // accepted edge past the debounce time: latch divisor, clear elapsed
      logic div_step;  // one restoring divide step
      logic load_out;  // update position and load the response register
   } renc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic bounced;   // edge would come before the debounce time
      logic accel_on;  // acceleration enabled
   } renc_status_type;

endpackage

FILE: sv/renc_ctrl.sv
// renc_ctrl: sequencer for ticks, edges and the shared divider
// depends on renc_pkg
module renc_ctrl
   import renc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_type,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  renc_status_type status,
   output renc_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    rsp_valid_ff;
   logic                    accept;
   logic                    out_free;

   // handshake and commands
   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign cmd.tick     = accept && (req_type == REQ_TICK);
   assign cmd.start    = accept && (req_type == REQ_EDGE) && !status.bounced;
   assign cmd.div_step = (state_ff == ST_DIV);
   assign cmd.load_out = (state_ff == ST_DONE) && out_free;
   assign rsp_valid    = rsp_valid_ff;

   // state, step counter and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.start) begin
                  cnt_ff   <= '0;
                  state_ff <= status.accel_on ? ST_DIV : ST_DONE;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_CNT_BITS'(STEP_BITS - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (cmd.load_out) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: sv/renc_dp.sv
// renc_dp: elapsed timer, configuration, restoring divider and position count
// depends on renc_pkg
module renc_dp
   import renc_pkg::*;
#(
   parameter int ELAPSED_BITS = 17,
   parameter int COUNT_BITS   = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_b_level,
   input  renc_cmd_type              cmd,
   output renc_status_type           status,
   output logic [OUT_COUNT_BITS-1:0] rsp_count_value,
   output logic [STEP_BITS-1:0]      rsp_step_amount
);

   localparam int SUM_BITS = (COUNT_BITS > STEP_BITS) ? COUNT_BITS : STEP_BITS;

   logic [CSR_DATA_BITS-1:0] debounce_ff;
   logic                     accel_ff;
   logic [ELAPSED_BITS-1:0]  elapsed_ff;
   logic [ELAPSED_BITS-1:0]  divisor_ff;
   logic [ELAPSED_BITS-1:0]  rem_ff;
   logic [ELAPSED_BITS-1:0]  rem_in;
   logic [STEP_BITS-1:0]     quo_ff;
   logic                     zero_ff;
   logic                     dir_ff;
   logic [COUNT_BITS-1:0]    pos_ff;
   logic [COUNT_BITS-1:0]    pos_in;
   logic [STEP_BITS-1:0]     step_in;
   logic [STEP_BITS-1:0]     step_ff;
   logic [OUT_COUNT_BITS-1:0] count_ff;
   logic [ELAPSED_BITS:0]    shifted;
   logic                     ge;
   logic [SUM_BITS-1:0]      step_wide;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         accel_ff    <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEBOUNCE:   debounce_ff <= csr_wdata;
            CSR_ACCELERATE: accel_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign status.bounced  = elapsed_ff < ELAPSED_BITS'(debounce_ff);
   assign status.accel_on = accel_ff;

   // saturating microsecond counter, cleared by an accepted edge past the debounce time
   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '1;
      end else if (cmd.start) begin
         elapsed_ff <= '0;
      end else if (cmd.tick && (elapsed_ff != '1)) begin
         elapsed_ff <= elapsed_ff + 1'b1;
      end
   end

   // restoring divide step: numerator bits shift out of quo_ff as quotient shifts in
   assign shifted = {rem_ff, quo_ff[STEP_BITS-1]};
   assign ge      = shifted >= {1'b0, divisor_ff};
   assign rem_in  = ge ? ELAPSED_BITS'(shifted - {1'b0, divisor_ff})
                       : shifted[ELAPSED_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         divisor_ff <= elapsed_ff;
         zero_ff    <= (elapsed_ff == '0);
         dir_ff     <= req_b_level;
         rem_ff     <= '0;
         quo_ff     <= SPEED_NUMERATOR;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[STEP_BITS-2:0], ge};
      end
   end

   // step size and next position
   always_comb begin
      if (!accel_ff) begin
         step_in = STEP_BITS'(1);
      end else if (zero_ff) begin
         step_in = SPEED_NUMERATOR + 1'b1;
      end else begin
         step_in = quo_ff + 1'b1;
      end
      step_wide = SUM_BITS'(step_in);
      if (dir_ff) begin
         pos_in = pos_ff + step_wide[COUNT_BITS-1:0];
      end else begin
         pos_in = pos_ff - step_wide[COUNT_BITS-1:0];
      end
   end

   // position count
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.load_out) begin
         pos_ff <= pos_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         step_ff  <= step_in;
         count_ff <= OUT_COUNT_BITS'($signed(pos_in));
      end
   end

   assign rsp_count_value = count_ff;
   assign rsp_step_amount = step_ff;

endmodule

FILE: sv/rotary_encoder_accel_counter_unit.sv
// Rotary encoder position counter with speed-dependent step size. Requests are
// microsecond ticks or channel A rising edges carrying the channel B level; each
// edge that passes the debounce time moves the position by the step and returns
// the new position and the step. With acceleration off, a passing edge goes
// straight to the done state; with acceleration on, a 17-step restoring divider
// (one quotient bit per cycle) first computes 1 + 100000 / elapsed. The done
// state loads the response register once it is free, rsp_valid is registered
// from that load and the next request can be taken after it. A finished edge
// waits without taking requests until the response register is free. Requests
// are not accepted while an edge is being worked on; ticks are still taken
// while a finished response waits on rsp_ready.
// depends on renc_pkg, renc_ctrl, renc_dp
module rotary_encoder_accel_counter_unit
   import renc_pkg::*;
#(
   parameter int ELAPSED_BITS = 17,
   parameter int COUNT_BITS   = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic                      req_b_level,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [OUT_COUNT_BITS-1:0] rsp_count_value,
   output logic [STEP_BITS-1:0]      rsp_step_amount
);

   renc_cmd_type    cmd;
   renc_status_type status;

   renc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   renc_dp #(
      .ELAPSED_BITS (ELAPSED_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_b_level     (req_b_level),
      .cmd             (cmd),
      .status          (status),
      .rsp_count_value (rsp_count_value),
      .rsp_step_amount (rsp_step_amount)
   );

   // no request taken while the divider runs
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_ready)
      else $error("request accepted during divide");

   // response register only loaded when free or draining
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("response overwritten");

   // a loaded response becomes visible next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded response not valid");

   // step is never zero on a valid response
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_amount != '0))
      else $error("zero step");

endmodule

FILE: tb/sv/rotary_encoder_accel_counter_unit_tb.sv
// testbench for rotary_encoder_accel_counter_unit: drives ticks and edges, predicts
// position and step per edge past the debounce time and checks each response in order
// depends on renc_pkg and rotary_encoder_accel_counter_unit
`timescale 1ns / 1ps

import renc_pkg::*;

typedef logic [16:0] gap_count_type;

typedef struct packed {
   logic [OUT_COUNT_BITS-1:0] count;
   logic [STEP_BITS-1:0]      step;
} encoder_move_type;

// tracks encoder state and the responses still owed by the block
class position_scoreboard;
   logic [CSR_DATA_BITS-1:0]  debounce_us;
   logic                      accel_on;
   gap_count_type             elapsed_us;
   logic [OUT_COUNT_BITS-1:0] position;
   encoder_move_type          expected_moves[$];
   int                        mismatch_count;

   function new();
      debounce_us    = DEBOUNCE_RESET;
      accel_on       = 1'b0;
      elapsed_us     = '1;
      position       = '0;
      mismatch_count = 0;
   endfunction

   function void write_registers(logic [CSR_DATA_BITS-1:0] debounce_word,
                                 logic [CSR_DATA_BITS-1:0] accel_word);
      debounce_us = debounce_word;
      accel_on    = accel_word[0];
   endfunction

   function int pending();
      return expected_moves.size();
   endfunction

   // step size from the time since the last edge that passed the debounce time
   function logic [STEP_BITS-1:0] speed_step(gap_count_type gap_us);
      if (!accel_on)
         return STEP_BITS'(1);
      if (gap_us == 0)
         return STEP_BITS'(100001);
      return STEP_BITS'(1 + 100000 / gap_us);
   endfunction

   // advance state on an accepted request, queue a response for a passing edge
   function void note_request(logic kind, logic b_high);
      encoder_move_type move;
      if (kind == REQ_TICK) begin
         if (elapsed_us != '1)
            elapsed_us = elapsed_us + 1'b1;
         return;
      end
      if (elapsed_us < {1'b0, debounce_us})
         return;
      move.step = speed_step(elapsed_us);
      if (b_high)
         position = position + OUT_COUNT_BITS'(move.step);
      else
         position = position - OUT_COUNT_BITS'(move.step);
      elapsed_us = '0;
      move.count = position;
      expected_moves = {expected_moves, move};
   endfunction

   task report_mismatch(string what, longint got, longint want);
      $display("%s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   task check_response(logic [OUT_COUNT_BITS-1:0] count, logic [STEP_BITS-1:0] step);
      encoder_move_type want;
      if (expected_moves.size() == 0) begin
         report_mismatch("response with none outstanding, count_value", $signed(count), 0);
         return;
      end
      want = expected_moves.pop_front();
      if (count !== want.count)
         report_mismatch("count_value", $signed(count), $signed(want.count));
      if (step !== want.step)
         report_mismatch("step_amount", step, want.step);
   endtask
endclass

module rotary_encoder_accel_counter_unit_tb;

   localparam int DRAIN_CYCLES    = 25;
   localparam int HOLD_CYCLES     = 400;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 104;

   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index    = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata    = '0;
   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   logic                      req_type     = REQ_TICK;
   logic                      req_b_level  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b0;
   logic [OUT_COUNT_BITS-1:0] rsp_count_value;
   logic [STEP_BITS-1:0]      rsp_step_amount;

   position_scoreboard sb = new();

   bit hold_request = 1'b0;
   int burst_left   = 0;

   rotary_encoder_accel_counter_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_b_level     (req_b_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_count_value (rsp_count_value),
      .rsp_step_amount (rsp_step_amount)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // offer one request, with a random gap when a burst runs out
   task automatic offer(input logic kind, input logic b_high);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_b_level <= b_high;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, b_high);
   endtask

   task automatic run_ticks(input int n);
      repeat (n) offer(REQ_TICK, 1'($urandom_range(0, 1)));
   endtask

   // stop offering, wait for all responses, then let a bounced edge finish
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write both registers on consecutive cycles
   task automatic configure(input logic [CSR_DATA_BITS-1:0] debounce_word,
                            input logic [CSR_DATA_BITS-1:0] accel_word);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DEBOUNCE;
      csr_wdata    <= debounce_word;
      @(posedge clock);
      csr_index    <= CSR_ACCELERATE;
      csr_wdata    <= accel_word;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.write_registers(debounce_word, accel_word);
   endtask

   // response side: stall pattern, one long hold on request, check every response
   initial begin : rsp_side
      int seg_left;
      int stall_pct;
      int hold_left;
      seg_left  = 0;
      stall_pct = 0;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_count_value, rsp_step_amount);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(4, 60);
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 30;
                  3: stall_pct = 60;
                  default: stall_pct = 90;
               endcase
            end
            seg_left--;
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // request side: directed cases, then random phases
   initial begin : req_side
      logic [CSR_DATA_BITS-1:0] deb;
      logic [CSR_DATA_BITS-1:0] acc;
      int sent;
      int n;
      int pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: saturated gap passes, then bounced edges
      offer(REQ_EDGE, 1'b1);
      offer(REQ_EDGE, 1'b0);
      offer(REQ_TICK, 1'b1);
      offer(REQ_TICK, 1'b0);
      offer(REQ_EDGE, 1'b0);
      settle();

      // no debounce with acceleration: zero and one microsecond gaps
      configure(16'd0, 16'h0001);
      offer(REQ_EDGE, 1'b1);
      offer(REQ_EDGE, 1'b0);
      offer(REQ_TICK, 1'b0);
      offer(REQ_EDGE, 1'b0);
      settle();

      // edge one tick short of the debounce time, then just at it
      configure(16'd3, 16'hFFFF);
      offer(REQ_TICK, 1'b1);
      offer(REQ_TICK, 1'b1);
      offer(REQ_EDGE, 1'b1);
      offer(REQ_TICK, 1'b0);
      offer(REQ_EDGE, 1'b1);
      settle();

      // largest debounce, acceleration cleared by a wide write
      configure(16'hFFFF, 16'hFFFE);
      offer(REQ_EDGE, 1'b1);
      settle();

      // random phases: mostly tick runs around the debounce time ending in an edge
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick = $urandom_range(0, 9);
         if (phase == 0)
            deb = 16'd1;
         else if (pick == 0)
            deb = 16'd0;
         else if (pick < 7)
            deb = CSR_DATA_BITS'($urandom_range(1, 8));
         else
            deb = CSR_DATA_BITS'($urandom_range(9, 40));
         acc = CSR_DATA_BITS'($urandom_range(0, 16'hFFFF));
         configure(deb, acc);
         if (phase == 2)
            hold_request = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: begin
                  n = int'(deb) + $urandom_range(0, 2);
                  if (deb != 0 && $urandom_range(0, 4) == 0)
                     n = int'(deb) - 1;
                  run_ticks(n);
                  offer(REQ_EDGE, 1'($urandom_range(0, 1)));
                  sent += n + 1;
               end
               7, 8: begin
                  n = $urandom_range(1, 3);
                  repeat (n) offer(REQ_EDGE, 1'($urandom_range(0, 1)));
                  sent += n;
               end
               default: begin
                  n = $urandom_range(1, 6);
                  repeat (n) offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  sent += n;
               end
            endcase
         end
         settle();
      end

      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("rotary_encoder_accel_counter_unit: match");
      else
         $display("rotary_encoder_accel_counter_unit: mismatch");
      $finish;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("rotary_encoder_accel_counter_unit: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
sv/renc_pkg.sv
sv/renc_ctrl.sv
sv/renc_dp.sv
sv/rotary_encoder_accel_counter_unit.sv
tb/sv/rotary_encoder_accel_counter_unit_tb.sv
